[sv/sync_framed_message_classifier_macros.svh]
// ----------------------------------------------------------------------------
// Sync-framed message classifier: assertion macros
// Concurrent assertion helpers. Defining NO_ASSERTIONS leaves them empty.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_MESSAGE_CLASSIFIER_MACROS_SVH
`define SYNC_FRAMED_MESSAGE_CLASSIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define SFMC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfmc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SFMC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfmc: next-cycle check failed");

`else

`define SFMC_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define SFMC_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[sv/sfmc_pkg.sv]
// ----------------------------------------------------------------------------
// Sync-framed message classifier package
// Constants, codes and the structures passed between the tracker and the
// classifier.
// ----------------------------------------------------------------------------
package sfmc_pkg;

	localparam int unsigned LEN_W = 17;

	// Framing and field constants.
	localparam logic [31:0] SYNC_WORD = 32'hFF00FF00;
	localparam logic [31:0] STAT_REDY = 32'h52454459;
	localparam logic [31:0] STAT_BUSY = 32'h42555359;
	localparam logic [LEN_W-1:0] COUNT_SAT = 17'd65540;
	localparam logic [LEN_W-1:0] LEN_SAT = 17'd65536;
	localparam logic [LEN_W-1:0] SYNC_LEN = 17'd4;
	localparam logic [LEN_W-1:0] MIN_CLOSE = 17'd8;
	localparam logic [LEN_W-1:0] OFF_SIZE_LO = 17'd4;
	localparam logic [LEN_W-1:0] OFF_SIZE_HI = 17'd5;
	localparam logic [LEN_W-1:0] OFF_STAT_FIRST = 17'd6;
	localparam logic [LEN_W-1:0] OFF_STAT_LAST = 17'd9;
	localparam logic [LEN_W-1:0] OFF_FUNC = 17'd11;
	localparam logic [LEN_W-1:0] MIN_LEN_STATUS = 17'd10;
	localparam logic [LEN_W-1:0] MIN_LEN_FUNC = 17'd12;
	localparam logic [7:0] FUNC_X = 8'h58;
	localparam logic [7:0] FUNC_V = 8'h56;
	localparam logic [7:0] FUNC_C = 8'h43;

	typedef enum logic [2:0] {
		KIND_INVALID   = 3'd0,
		KIND_BUSY      = 3'd1,
		KIND_UNKNOWN   = 3'd2,
		KIND_HANDSHAKE = 3'd3,
		KIND_V         = 3'd4,
		KIND_PING      = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_REDY  = 2'd0,
		STATUS_BUSY  = 2'd1,
		STATUS_OTHER = 2'd2
	} status_code_t;

	// Raw fields of a closed message, as captured by the tracker.
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [15:0]      size;
		logic [31:0]      status;
		logic [7:0]       func;
	} msg_fields_t;

	// Classified result of one message.
	typedef struct packed {
		kind_t            kind;
		logic [LEN_W-1:0] length;
		logic [15:0]      size;
		status_code_t     status;
		logic [7:0]       func;
	} msg_result_t;

	// Framing state seen from outside the tracker.
	typedef struct packed {
		logic             in_message;
		logic [LEN_W-1:0] byte_count;
	} trk_state_t;

endpackage

[sv/sync_framed_message_classifier.sv]
// ----------------------------------------------------------------------------
// Sync-framed message classifier
// Usage:
//   Bytes of a received buffer enter on the byte channel (byte_valid,
//   byte_stall, data_byte, end_of_buffer), one beat per byte, with
//   end_of_buffer set on the buffer's last byte. Each message starts at a
//   sync word FF 00 FF 00 and closes at the next sync or at buffer end.
//   One result beat per closed message leaves on the msg channel
//   (msg_valid, msg_stall and the msg_* fields); many bytes give no result.
//   msg_valid rises once the byte that closes its message has passed the
//   input register and then the result register; a stall on the msg
//   channel can hold that byte in the input register between the two.
//   Throughput: one byte per cycle while byte_stall is low. Reset clears
//   the framing state and the valid bits of both registers; hunting starts
//   afresh. While msg_stall holds a waiting result, byte_stall rises only
//   once a byte is also waiting in the input register.
//   Nothing spans two buffers: all framing state clears after each last byte.
// ----------------------------------------------------------------------------
`include "sync_framed_message_classifier_macros.svh"

module sync_framed_message_classifier
	import sfmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        msg_valid,
	input  logic        msg_stall,
	output logic [2:0]  msg_kind,
	output logic [16:0] msg_length,
	output logic [15:0] reported_size,
	output logic [1:0]  status_code,
	output logic [7:0]  function_code
);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        eob_s1;
	logic        out_free;
	logic        step;
	logic        emit;
	msg_fields_t fields;
	msg_result_t result;
	msg_result_t result_q;
	logic        result_valid_q;
	trk_state_t  trk_state;
	logic        len_matches;

	// The input register moves on whenever the result register can take.
	assign out_free = !result_valid_q || !msg_stall;
	assign step = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_s1 <= data_byte;
			eob_s1 <= end_of_buffer;
		end
	end

	sfmc_tracker u_tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.data_byte     (data_s1),
		.end_of_buffer (eob_s1),
		.emit          (emit),
		.fields        (fields),
		.state         (trk_state)
	);

	sfmc_classify u_classify (
		.fields (fields),
		.result (result)
	);

	// Result register: loaded with a closed message, held while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			result_q <= result;
		end
	end

	assign msg_valid = result_valid_q;
	assign msg_kind = result_q.kind;
	assign msg_length = result_q.length;
	assign reported_size = result_q.size;
	assign status_code = result_q.status;
	assign function_code = result_q.func;

	// The length on the output agrees with the reported size field.
	assign len_matches = (msg_length == {1'b0, reported_size});

	// A classified message always agrees with its size field.
	`SFMC_ASSERT_SAME(a_kind_size, clk, arst_n, msg_valid && (msg_kind != KIND_INVALID), len_matches)
	// Reported lengths never exceed the saturation value.
	`SFMC_ASSERT_SAME(a_len_sat, clk, arst_n, msg_valid, msg_length <= LEN_SAT)
	// While hunting, the byte count stays cleared.
	`SFMC_ASSERT_SAME(a_hunt_count, clk, arst_n, !trk_state.in_message, trk_state.byte_count == '0)
	// A processed last byte leaves the tracker hunting.
	`SFMC_ASSERT_NEXT(a_eob_clear, clk, arst_n, step && eob_s1, !trk_state.in_message)

endmodule

[sv/sfmc_tracker.sv]
// ----------------------------------------------------------------------------
// Sync-framed message classifier: framing tracker
// Hunts for the sync word, counts message bytes, captures the fixed-offset
// fields and signals when a message closes.
// ----------------------------------------------------------------------------
module sfmc_tracker
	import sfmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        emit,
	output msg_fields_t fields,
	output trk_state_t  state
);

	logic [23:0]      sync_window_q;
	logic             in_message_q;
	logic [LEN_W-1:0] byte_count_q;
	logic [15:0]      size_q;
	logic [31:0]      status_q;
	logic [7:0]       func_q;

	logic [23:0]      sync_window_d;
	logic             in_message_d;
	logic [LEN_W-1:0] byte_count_d;
	logic [15:0]      size_d;
	logic [31:0]      status_d;
	logic [7:0]       func_d;

	logic [31:0]      win4;
	logic             is_sync;
	logic [LEN_W-1:0] cnt;
	logic [LEN_W-1:0] off;
	logic [15:0]      cap_size;
	logic [31:0]      cap_status;
	logic [7:0]       cap_func;
	logic             sync_close;

	// Next framing state, field capture and close detection for one byte.
	always_comb begin
		win4 = {sync_window_q, data_byte};
		is_sync = (win4 == SYNC_WORD);
		cnt = (byte_count_q >= COUNT_SAT) ? COUNT_SAT : byte_count_q + 17'd1;
		off = cnt - 17'd1;

		cap_size = size_q;
		cap_status = status_q;
		cap_func = func_q;
		if (in_message_q) begin
			if (off == OFF_SIZE_LO) begin
				cap_size = {size_q[15:8], data_byte};
			end else if (off == OFF_SIZE_HI) begin
				cap_size = {data_byte, size_q[7:0]};
			end else if (off >= OFF_STAT_FIRST && off <= OFF_STAT_LAST) begin
				cap_status = {status_q[23:0], data_byte};
			end else if (off == OFF_FUNC) begin
				cap_func = data_byte;
			end
		end

		sync_close = in_message_q && is_sync && (cnt >= MIN_CLOSE);

		in_message_d = in_message_q;
		byte_count_d = byte_count_q;
		size_d = cap_size;
		status_d = cap_status;
		func_d = cap_func;
		emit = 1'b0;
		fields.len = cnt - SYNC_LEN;
		fields.size = cap_size;
		fields.status = cap_status;
		fields.func = cap_func;

		if (in_message_q) begin
			if (sync_close) begin
				emit = 1'b1;
				byte_count_d = SYNC_LEN;
				size_d = '0;
				status_d = '0;
				func_d = '0;
			end else begin
				byte_count_d = cnt;
			end
		end else if (is_sync) begin
			in_message_d = 1'b1;
			byte_count_d = SYNC_LEN;
			size_d = '0;
			status_d = '0;
			func_d = '0;
		end

		// The end of the buffer closes a running message and clears everything.
		if (end_of_buffer) begin
			if (in_message_q && !sync_close && cnt > SYNC_LEN) begin
				emit = 1'b1;
				fields.len = (cnt > LEN_SAT) ? LEN_SAT : cnt;
			end
			sync_window_d = '0;
			in_message_d = 1'b0;
			byte_count_d = '0;
			size_d = '0;
			status_d = '0;
			func_d = '0;
		end else begin
			sync_window_d = win4[23:0];
		end
	end

	// State registers advance once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_window_q <= '0;
			in_message_q <= 1'b0;
			byte_count_q <= '0;
			size_q <= '0;
			status_q <= '0;
			func_q <= '0;
		end else if (step) begin
			sync_window_q <= sync_window_d;
			in_message_q <= in_message_d;
			byte_count_q <= byte_count_d;
			size_q <= size_d;
			status_q <= status_d;
			func_q <= func_d;
		end
	end

	assign state.in_message = in_message_q;
	assign state.byte_count = byte_count_q;

endmodule

[sv/sfmc_classify.sv]
// ----------------------------------------------------------------------------
// Sync-framed message classifier: classification
// Masks the captured fields by message length and derives the message kind.
// ----------------------------------------------------------------------------
module sfmc_classify
	import sfmc_pkg::*;
(
	input  msg_fields_t fields,
	output msg_result_t result
);

	logic [15:0]  rsize;
	status_code_t stat;
	logic [7:0]   func;
	kind_t        kind;

	// Fields lying past the end of the message read as zero or "other".
	always_comb begin
		rsize[7:0] = (fields.len > OFF_SIZE_LO) ? fields.size[7:0] : 8'h00;
		rsize[15:8] = (fields.len > OFF_SIZE_HI) ? fields.size[15:8] : 8'h00;
		stat = STATUS_OTHER;
		if (fields.len >= MIN_LEN_STATUS) begin
			if (fields.status == STAT_REDY) begin
				stat = STATUS_REDY;
			end else if (fields.status == STAT_BUSY) begin
				stat = STATUS_BUSY;
			end
		end
		func = (fields.len >= MIN_LEN_FUNC) ? fields.func : 8'h00;
	end

	// Kind decision, in order of precedence.
	always_comb begin
		priority if (fields.len < MIN_LEN_STATUS || fields.len != {1'b0, rsize}) begin
			kind = KIND_INVALID;
		end else if (stat == STATUS_BUSY) begin
			kind = KIND_BUSY;
		end else if (stat == STATUS_OTHER) begin
			kind = KIND_UNKNOWN;
		end else if (fields.len < MIN_LEN_FUNC) begin
			kind = KIND_UNKNOWN;
		end else if (func == FUNC_X) begin
			kind = KIND_HANDSHAKE;
		end else if (func == FUNC_V) begin
			kind = KIND_V;
		end else if (func == FUNC_C) begin
			kind = KIND_PING;
		end else begin
			kind = KIND_UNKNOWN;
		end
	end

	assign result.kind = kind;
	assign result.length = fields.len;
	assign result.size = rsize;
	assign result.status = stat;
	assign result.func = func;

endmodule
